>>> rtl/sparse_set_index_map_macros.svh
// Assertion macros for the sparse set index map.
// Used by the top level; expects clk and rst in the including scope.
`ifndef SPARSE_SET_INDEX_MAP_MACROS_SVH
`define SPARSE_SET_INDEX_MAP_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define SSIM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sparse set index map check failed");

// The consequent holds in the cycle after the antecedent.
`define SSIM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sparse set index map check failed");

`endif

>>> rtl/ssim_pkg.sv
// Shared types and constants for the sparse set index map.
// No dependencies; imported by the interface users, controller and datapath.
package ssim_pkg;

  localparam int IDX_W   = 10;
  localparam int GEN_W   = 8;
  localparam int SLOT_W  = 8;
  localparam int COUNT_W = 9;

  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_LOOKUP = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_PRESENT = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_ABSENT  = 2'd3;

  typedef struct packed {
    logic [1:0]       command;
    logic [IDX_W-1:0] entity_index;
    logic [GEN_W-1:0] entity_generation;
  } ssim_req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [SLOT_W-1:0]  slot;
    logic               moved;
    logic [SLOT_W-1:0]  moved_from;
    logic [COUNT_W-1:0] count;
  } ssim_rsp_t;

  // Controller to datapath.
  typedef struct packed {
    logic clear_step;
    logic capture;
    logic lookup_slot;
    logic eval;
    logic apply_move;
  } ssim_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic clear_last;
    logic out_free;
    logic need_move;
  } ssim_sts_t;

endpackage

>>> rtl/ssim_stream_if.sv
// Valid/ready stream interface carrying one word of a given payload type.
// No dependencies; the payload types come from ssim_pkg at instantiation.
interface ssim_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/sparse_set_index_map.sv
// Top level of the sparse set index map (swap-and-pop sparse set).
// Depends on ssim_pkg, ssim_stream_if, ssim_ctrl, ssim_datapath and the macro header.
//
//   Channel  Dir  Word                                         Accepted when
//   req      in   command, entity_index, entity_generation     req.valid && req.ready
//   rsp      out  status, slot, moved, moved_from, count       rsp.valid && rsp.ready
//
// Add and lookup go through the sparse read and evaluation steps from acceptance to
// the result register; a remove that moves the tail entry adds a move step, as the
// tail is first read from the one-port dense table. A new word is accepted in the
// cycle after the result is loaded. After reset a clearing pass over all MAX_ENTITIES
// entries empties the sparse valid bits, one entry a cycle; req.ready is low until done.
// A stalled rsp holds its word; the block then waits in its evaluation step with no writes.
module sparse_set_index_map #(
  parameter int MAX_ENTITIES = 1024,
  parameter int CAPACITY     = 256,
  parameter int GEN_BITS     = 8
) (
  input logic           clk,
  input logic           rst,
  ssim_stream_if.sink   req,
  ssim_stream_if.source rsp
);
  import ssim_pkg::*;

  // The controller only sequences the work; every table, the count and the
  // result register live in the datapath.
  ssim_cmd_t cmd;
  ssim_sts_t sts;

  ssim_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ssim_datapath #(
    .MAX_ENTITIES (MAX_ENTITIES),
    .CAPACITY     (CAPACITY),
    .GEN_BITS     (GEN_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req_data  (req.data),
    .cmd       (cmd),
    .sts       (sts),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data)
  );

`include "sparse_set_index_map_macros.svh"

  // The block never takes a word while the clearing pass still runs.
  `SSIM_ASSERT_NOW(a_no_accept_in_clear, req.ready, !cmd.clear_step)
  // The sparse read of an accepted word needs the following cycle.
  `SSIM_ASSERT_NEXT(a_busy_after_accept, req.valid && req.ready, !req.ready)
  // A remove that moves the tail keeps the block busy for the move step.
  `SSIM_ASSERT_NEXT(a_busy_for_move, cmd.eval && sts.need_move, !req.ready && !rsp.valid)
  // A fresh result only comes from the last step of an item, which frees the input.
  `SSIM_ASSERT_NOW(a_ready_after_result, $rose(rsp.valid), req.ready)

endmodule

>>> rtl/ssim_ctrl.sv
// Controller state machine for the sparse set index map.
// Depends on ssim_pkg for the command and status structs.
module ssim_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  ssim_pkg::ssim_sts_t sts,
  output ssim_pkg::ssim_cmd_t cmd
);
  import ssim_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_SPARSE = 5'b00100,
    S_EVAL   = 5'b01000,
    S_MOVE   = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        req_ready   = 1'b1;
        cmd.capture = req_valid;
        if (req_valid) begin
          state_next = S_SPARSE;
        end
      end
      S_SPARSE: begin
        cmd.lookup_slot = 1'b1;
        state_next      = S_EVAL;
      end
      S_EVAL: begin
        // Waits here until the result register can take a word.
        cmd.eval = sts.out_free;
        if (sts.out_free) begin
          state_next = sts.need_move ? S_MOVE : S_IDLE;
        end
      end
      S_MOVE: begin
        cmd.apply_move = sts.out_free;
        if (sts.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

endmodule

>>> rtl/ssim_datapath.sv
// Datapath of the sparse set index map: sparse and dense tables, count, result.
// Depends on ssim_pkg; driven by ssim_ctrl through command and status structs.
module ssim_datapath #(
  parameter int MAX_ENTITIES = 1024,
  parameter int CAPACITY     = 256,
  parameter int GEN_BITS     = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  ssim_pkg::ssim_req_t req_data,
  input  ssim_pkg::ssim_cmd_t cmd,
  output ssim_pkg::ssim_sts_t sts,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output ssim_pkg::ssim_rsp_t rsp_data
);
  import ssim_pkg::*;

  localparam int AW  = $clog2(MAX_ENTITIES);
  localparam int SW  = $clog2(CAPACITY);
  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int IDW = (AW < IDX_W) ? AW : IDX_W;
  localparam int GW  = (GEN_BITS < GEN_W) ? GEN_BITS : GEN_W;
  localparam int DW  = IDW + GW;

  // Captured request.
  logic [1:0]       cmd_q;
  logic [IDX_W-1:0] idx_q;
  logic [GW-1:0]    gen_q;

  // Sparse table split into a valid array and a slot array so that a move
  // can patch the slot without touching the valid bit.
  logic          vld_mem  [MAX_ENTITIES];
  logic [SW-1:0] slot_mem [MAX_ENTITIES];
  logic [DW-1:0] dense_mem [CAPACITY];

  logic          vld_rd;
  logic [SW-1:0] slot_rd;
  logic [DW-1:0] dense_rd;

  logic [CW-1:0] count_q;
  logic [CW-1:0] count_next;
  logic [AW-1:0] clr_addr;
  logic          sp_hit;

  logic [31:0]   in_wide;
  logic [31:0]   idx_wide;
  logic [31:0]   mi_wide;
  logic [AW-1:0] in_addr;
  logic [AW-1:0] idx_addr;
  logic [AW-1:0] mi_addr;
  logic          in_range;

  logic [IDW-1:0] dn_idx;
  logic [GW-1:0]  dn_gen;
  logic           present;
  logic [CW-1:0]  last;
  logic           slot_is_last;
  logic           full;
  logic           is_add;
  logic           is_remove;
  logic           need_move;
  logic           finish;

  logic          vld_we;
  logic          vld_wdata;
  logic [AW-1:0] vld_addr;
  logic          slot_we;
  logic [SW-1:0] slot_wdata;
  logic [AW-1:0] slot_addr;
  logic          dense_we;
  logic          dense_re;
  logic [DW-1:0] dense_wdata;
  logic [SW-1:0] dense_addr;

  logic [1:0]    r_status;
  logic [SW-1:0] r_slot;
  logic          r_moved;
  logic [SW-1:0] r_from;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_q <= req_data.command;
      idx_q <= req_data.entity_index;
      gen_q <= req_data.entity_generation[GW-1:0];
    end
  end

  assign in_wide  = 32'(req_data.entity_index);
  assign in_addr  = in_wide[AW-1:0];
  assign idx_wide = 32'(idx_q);
  assign idx_addr = idx_wide[AW-1:0];
  assign in_range = idx_wide < 32'(MAX_ENTITIES);

  assign dn_idx  = dense_rd[DW-1:GW];
  assign dn_gen  = dense_rd[GW-1:0];
  assign mi_wide = 32'(dn_idx);
  assign mi_addr = mi_wide[AW-1:0];

  assign present      = sp_hit && (mi_wide == idx_wide) && (dn_gen == gen_q);
  assign last         = CW'(count_q - CW'(1));
  assign slot_is_last = CW'(slot_rd) == last;
  assign full         = !in_range || (count_q == CW'(CAPACITY));
  assign is_add       = cmd_q == CMD_ADD;
  assign is_remove    = cmd_q == CMD_REMOVE;
  assign need_move    = is_remove && present && !slot_is_last;
  assign finish       = (cmd.eval && !need_move) || cmd.apply_move;

  always_comb begin
    vld_we      = 1'b0;
    vld_wdata   = 1'b0;
    vld_addr    = in_addr;
    slot_we     = 1'b0;
    slot_wdata  = slot_rd;
    slot_addr   = in_addr;
    dense_we    = 1'b0;
    dense_re    = 1'b0;
    dense_wdata = dense_rd;
    dense_addr  = slot_rd;
    count_next  = count_q;
    r_status    = ST_OK;
    r_slot      = slot_rd;
    r_moved     = 1'b0;
    r_from      = '0;

    if (cmd.clear_step) begin
      vld_we   = 1'b1;
      vld_addr = clr_addr;
    end

    if (cmd.lookup_slot) begin
      dense_re = 1'b1;
    end

    if (cmd.eval) begin
      if (need_move) begin
        // Fetch the tail entry; the move itself is applied next.
        dense_re   = 1'b1;
        dense_addr = last[SW-1:0];
      end else if (is_add) begin
        if (present) begin
          r_status = ST_PRESENT;
        end else if (full) begin
          r_status = ST_FULL;
          r_slot   = '0;
        end else begin
          vld_we      = 1'b1;
          vld_wdata   = 1'b1;
          vld_addr    = idx_addr;
          slot_we     = 1'b1;
          slot_wdata  = count_q[SW-1:0];
          slot_addr   = idx_addr;
          dense_we    = 1'b1;
          dense_addr  = count_q[SW-1:0];
          dense_wdata = {idx_q[IDW-1:0], gen_q};
          count_next  = CW'(count_q + CW'(1));
          r_slot      = count_q[SW-1:0];
        end
      end else if (is_remove) begin
        if (!present) begin
          r_status = ST_ABSENT;
          r_slot   = '0;
        end else begin
          vld_we     = 1'b1;
          vld_addr   = idx_addr;
          count_next = last;
        end
      end else begin
        if (!present) begin
          r_status = ST_ABSENT;
          r_slot   = '0;
        end
      end
    end

    if (cmd.apply_move) begin
      // Tail entry into the hole, its sparse slot patched, removed index
      // cleared; the clear wins when both name the same index.
      dense_we   = 1'b1;
      dense_addr = slot_rd;
      slot_we    = 1'b1;
      slot_addr  = mi_addr;
      vld_we     = 1'b1;
      vld_addr   = idx_addr;
      count_next = last;
      r_moved    = 1'b1;
      r_from     = last[SW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (vld_we) begin
      vld_mem[vld_addr] <= vld_wdata;
    end else if (cmd.capture) begin
      vld_rd <= vld_mem[vld_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_addr] <= slot_wdata;
    end else if (cmd.capture) begin
      slot_rd <= slot_mem[slot_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (dense_we) begin
      dense_mem[dense_addr] <= dense_wdata;
    end else if (dense_re) begin
      dense_rd <= dense_mem[dense_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lookup_slot) begin
      sp_hit <= in_range && vld_rd && (CW'(slot_rd) < count_q);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count_q  <= '0;
      clr_addr <= '0;
    end else begin
      count_q <= count_next;
      if (cmd.clear_step) begin
        clr_addr <= AW'(clr_addr + AW'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (finish) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      rsp_data.status     <= r_status;
      rsp_data.slot       <= SLOT_W'(r_slot);
      rsp_data.moved      <= r_moved;
      rsp_data.moved_from <= SLOT_W'(r_from);
      rsp_data.count      <= COUNT_W'(count_next);
    end
  end

  assign sts.clear_last = clr_addr == AW'(MAX_ENTITIES - 1);
  assign sts.out_free   = !rsp_valid || rsp_ready;
  assign sts.need_move  = need_move;

endmodule
